FILE: hdl/elrb_pkg.sv
// Shared types, codes and constants of the event log ring buffer.
package elrb_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int IDX_W     = 8;
  localparam int COUNT_W   = 4;

  localparam logic       REQ_APPEND = 1'b0;
  localparam logic       REQ_READ   = 1'b1;

  localparam logic [1:0] TYPE_ERROR = 2'd0;

  localparam logic [1:0] STAT_ACTIVE = 2'd0;
  localparam logic [1:0] STAT_READ   = 2'd2;

  localparam logic [1:0] NS_KEEP = 2'd0;

  typedef struct packed {
    logic              req_type;
    logic [31:0]       uptime;
    logic [1:0]        entry_type;
    logic [7:0]        category;
    logic [7:0]        event_code;
    logic [15:0]       info;
    logic [IDX_W-1:0]  read_index;
    logic [1:0]        new_status;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [31:0]        uptime_out;
    logic [1:0]         type_out;
    logic [7:0]         category_out;
    logic [7:0]         code_out;
    logic [15:0]        info_out;
    logic [1:0]         status_out;
    logic [COUNT_W-1:0] entry_count;
    logic               unread_error;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  entry_type;
    logic [7:0]  category;
    logic [7:0]  event_code;
    logic [15:0] info;
    logic [1:0]  status;
  } body_t;

  typedef struct packed {
    logic wr_stamp;
    logic wr_body;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SCAN
  } state_t;

endpackage

FILE: hdl/elrb_store.sv
// Entry storage: timestamp and body memories on one shared address, registered read.
module elrb_store #(
  parameter int DEPTH = elrb_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  elrb_pkg::mem_ctl_t       mem_ctl,
  input  logic [$clog2(DEPTH)-1:0] mem_addr,
  input  logic [31:0]              stamp_wdata,
  input  elrb_pkg::body_t          body_wdata,
  output logic [31:0]              stamp_rdata,
  output elrb_pkg::body_t          body_rdata
);
  import elrb_pkg::*;

  logic [31:0] stamp_mem [DEPTH];
  body_t       body_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_stamp) begin
      stamp_mem[mem_addr] <= stamp_wdata;
    end
    stamp_rdata <= stamp_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_body) begin
      body_mem[mem_addr] <= body_wdata;
    end
    body_rdata <= body_mem[mem_addr];
  end

endmodule

FILE: hdl/event_log_ring_buffer.sv
// Top level of the event log ring buffer: control sequencer, pointers and error flag.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+-------------------------------------
//  input   | start, busy, in_item          | transaction taken when start && !busy
//  result  | out_valid, out_item           | one-cycle strobe, always taken
//
// An append's result appears the cycle after acceptance.
// A read without status change returns from S_RD_WAIT. A read with a status change
// writes the new status back and rescans from the oldest entry: the rescan reads one
// entry per cycle through the single memory port, checks each entry in the cycle
// after issuing it, closes once the last check is done, and stops early at the first
// unread error. Reset clears the pointers, the flag and the sequencer; the
// memories are not cleared. The receiver cannot stall, so nothing waits on the
// result side.
module event_log_ring_buffer #(
  parameter int DEPTH = elrb_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  elrb_pkg::in_item_t  in_item,
  output logic                out_valid,
  output elrb_pkg::out_item_t out_item
);
  import elrb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = (PTR_W > IDX_W) ? PTR_W : IDX_W;

  // Pointer arithmetic modulo DEPTH
  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] held_count(input logic [PTR_W-1:0] nxt,
                                                  input logic [PTR_W-1:0] old);
    logic [PTR_W:0] d;
    if (nxt >= old) begin
      d = {1'b0, nxt} - {1'b0, old};
    end else begin
      d = (PTR_W+1)'(DEPTH) + {1'b0, nxt} - {1'b0, old};
    end
    return d[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] old,
                                               input logic [PTR_W-1:0] age);
    logic [PTR_W:0] s;
    s = {1'b0, old} + {1'b0, age};
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] oldest_r, oldest_nxt;
  logic [PTR_W-1:0] next_r, next_nxt;
  logic             flag_r, flag_nxt;
  logic [PTR_W-1:0] slot_r, slot_nxt;
  logic [1:0]       ns_r, ns_nxt;
  logic [PTR_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  mem_ctl_t         mem_ctl;
  logic [PTR_W-1:0] mem_addr;
  logic [31:0]      stamp_wdata;
  body_t            body_wdata;
  logic [31:0]      stamp_rdata;
  body_t            body_rdata;

  logic [PTR_W-1:0] cur_count;
  logic             hit;
  logic             issue;
  logic             unread_err;
  logic             finish;

  elrb_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk        (clk),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .stamp_wdata(stamp_wdata),
    .body_wdata (body_wdata),
    .stamp_rdata(stamp_rdata),
    .body_rdata (body_rdata)
  );

  assign cur_count  = held_count(next_r, oldest_r);
  assign hit        = CMP_W'(in_item.read_index) < CMP_W'(cur_count);
  assign issue      = scan_idx_r < cur_count;
  assign unread_err = chk_v_r && (body_rdata.status != STAT_READ) &&
                      (body_rdata.entry_type == TYPE_ERROR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      next_r      <= '0;
      flag_r      <= 1'b0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      next_r      <= next_nxt;
      flag_r      <= flag_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    ns_r       <= ns_nxt;
    scan_idx_r <= scan_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    next_nxt      = next_r;
    flag_nxt      = flag_r;
    slot_nxt      = slot_r;
    ns_nxt        = ns_r;
    scan_idx_nxt  = scan_idx_r;
    chk_v_nxt     = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_ctl       = '0;
    mem_addr      = slot_r;
    stamp_wdata   = in_item.uptime;
    body_wdata    = '{entry_type: in_item.entry_type, category: in_item.category,
                      event_code: in_item.event_code, info: in_item.info,
                      status: STAT_ACTIVE};
    finish        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.req_type)
            REQ_APPEND: begin
              // store at the write slot; drop the oldest entry when the log is full
              mem_addr         = next_r;
              mem_ctl.wr_stamp = 1'b1;
              mem_ctl.wr_body  = 1'b1;
              next_nxt         = wrap_inc(next_r);
              if (wrap_inc(next_r) == oldest_r) begin
                oldest_nxt = wrap_inc(oldest_r);
              end
              if (in_item.entry_type == TYPE_ERROR) begin
                flag_nxt = 1'b1;
              end
              out_item_nxt = '0;
              finish       = 1'b1;
            end
            REQ_READ: begin
              if (hit) begin
                slot_nxt  = slot_of(oldest_r, in_item.read_index[PTR_W-1:0]);
                mem_addr  = slot_of(oldest_r, in_item.read_index[PTR_W-1:0]);
                ns_nxt    = in_item.new_status;
                state_nxt = S_RD_WAIT;
              end else begin
                // out of range: report not found, change nothing
                out_item_nxt = '0;
                finish       = 1'b1;
              end
            end
            default: begin
              out_item_nxt = '0;
              finish       = 1'b1;
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        // latch the entry with its old status
        out_item_nxt.found        = 1'b1;
        out_item_nxt.uptime_out   = stamp_rdata;
        out_item_nxt.type_out     = body_rdata.entry_type;
        out_item_nxt.category_out = body_rdata.category;
        out_item_nxt.code_out     = body_rdata.event_code;
        out_item_nxt.info_out     = body_rdata.info;
        out_item_nxt.status_out   = body_rdata.status;
        if (ns_r == NS_KEEP) begin
          finish = 1'b1;
        end else begin
          // write back the new status, then rescan from the oldest entry
          body_wdata        = body_rdata;
          body_wdata.status = ns_r - 2'd1;
          mem_ctl.wr_body   = 1'b1;
          scan_idx_nxt      = '0;
          flag_nxt          = 1'b0;
          state_nxt         = S_SCAN;
        end
      end

      S_SCAN: begin
        mem_addr = slot_of(oldest_r, scan_idx_r);
        if (issue) begin
          scan_idx_nxt = scan_idx_r + PTR_W'(1);
          chk_v_nxt    = 1'b1;
        end
        if (unread_err) begin
          flag_nxt  = 1'b1;
          chk_v_nxt = 1'b0;
          finish    = 1'b1;
        end else if (!issue && !chk_v_r) begin
          finish = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.entry_count  = COUNT_W'(held_count(next_nxt, oldest_nxt));
      out_item_nxt.unread_error = flag_nxt;
      state_nxt                 = S_IDLE;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_r <= PTR_W'(DEPTH - 1)) && (next_r <= PTR_W'(DEPTH - 1)))
    else $error("ring pointer beyond last slot");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid_r || (state_r != S_IDLE)))
    else $error("accepted transaction neither answered nor in progress");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.found) |->
      ((out_item_r.uptime_out == 32'd0) && (out_item_r.info_out == 16'd0) &&
       (out_item_r.status_out == 2'd0)))
    else $error("result without entry carries entry data");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_idx_r <= cur_count))
    else $error("rescan index ran past held entries");

  a_ptr_stable_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> ($stable(oldest_r) && $stable(next_r)))
    else $error("pointers moved during a read");
`endif

endmodule
